// ===== design/jfp_pkg.sv =====
`default_nettype none
package jfp_pkg;

  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_HEIGHT     = 4096;
  localparam int VALUE_BITS     = 32;
  localparam int MIN_SIZE       = 3;

  localparam int COL_BITS       = $clog2(MAX_WIDTH);
  localparam int ROW_BITS       = $clog2(MAX_HEIGHT);
  localparam int GW_BITS        = 11;
  localparam int GH_BITS        = 13;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 13;

  localparam int OUT_FIELD_BITS = VALUE_BITS + ROW_BITS + COL_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_FIELD_BITS;

  localparam logic [GW_BITS-1:0] GW_RESET = GW_BITS'(1024);
  localparam logic [GH_BITS-1:0] GH_RESET = GH_BITS'(4096);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_index_t;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  // scan position of the word being accepted
  typedef struct packed {
    logic [COL_BITS-1:0] col;
    logic [ROW_BITS-1:0] point_row;
    logic                emit;
    logic                last;
  } pos_t;

endpackage
`default_nettype wire

// ===== design/jfp_ram.sv =====
`default_nettype none
module jfp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/jfp_scan.sv =====
`default_nettype none
module jfp_scan (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [jfp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [jfp_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  wire logic                                 advance,
  output jfp_pkg::pos_t                             pos
);
  import jfp_pkg::*;

  logic [GW_BITS-1:0]  grid_width;
  logic [GH_BITS-1:0]  grid_height;
  logic [COL_BITS-1:0] col;
  logic [ROW_BITS-1:0] row;

  logic [GW_BITS-1:0]  w_eff;
  logic [GH_BITS-1:0]  h_eff;
  logic [GW_BITS-1:0]  col_wide;
  logic [GH_BITS-1:0]  row_wide;
  logic                col_wrap;
  logic                row_wrap;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (grid_width < GW_BITS'(MIN_SIZE)) begin
      w_eff = GW_BITS'(MIN_SIZE);
    end else if (grid_width > GW_BITS'(MAX_WIDTH)) begin
      w_eff = GW_BITS'(MAX_WIDTH);
    end else begin
      w_eff = grid_width;
    end
    if (grid_height < GH_BITS'(MIN_SIZE)) begin
      h_eff = GH_BITS'(MIN_SIZE);
    end else if (grid_height > GH_BITS'(MAX_HEIGHT)) begin
      h_eff = GH_BITS'(MAX_HEIGHT);
    end else begin
      h_eff = grid_height;
    end
  end

  assign col_wide = GW_BITS'(col);
  assign row_wide = GH_BITS'(row);
  assign col_wrap = (col_wide + GW_BITS'(1)) >= w_eff;
  assign row_wrap = (row_wide + GH_BITS'(1)) >= h_eff;

  always_comb begin
    pos.col       = col;
    pos.point_row = row - ROW_BITS'(1);
    pos.emit      = (row >= ROW_BITS'(2)) && (row_wide <= h_eff - GH_BITS'(1)) &&
                    (col >= COL_BITS'(1)) && (col_wide <= w_eff - GW_BITS'(2));
    pos.last      = (row_wide == h_eff - GH_BITS'(1)) && (col_wide == w_eff - GW_BITS'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GW_RESET;
      grid_height <= GH_RESET;
      col         <= '0;
      row         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_GRID_WIDTH:  grid_width  <= cfg_data[GW_BITS-1:0];
          CFG_GRID_HEIGHT: grid_height <= cfg_data[GH_BITS-1:0];
        endcase
      end
      if (advance) begin
        if (col_wrap) begin
          col <= '0;
          row <= row_wrap ? '0 : row + ROW_BITS'(1);
        end else begin
          col <= col + COL_BITS'(1);
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    advance && col_wrap |=> col == '0)
    else $error("column did not wrap at end of row");
  a_col_step: assert property (@(posedge clk) disable iff (rst)
    advance && !col_wrap |=> col == $past(col) + COL_BITS'(1) && row == $past(row))
    else $error("column step wrong");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(col) && $stable(row))
    else $error("scan moved without a word");
  a_emit_interior: assert property (@(posedge clk) disable iff (rst)
    pos.emit |-> col != '0 && row >= ROW_BITS'(2))
    else $error("border point marked for output");
`endif

endmodule
`default_nettype wire

// ===== design/jfp_stencil.sv =====
`default_nettype none
module jfp_stencil (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s1_valid,
  input  wire jfp_pkg::pos_t                        s1_pos,
  input  wire logic [jfp_pkg::VALUE_BITS-1:0]       up,
  input  wire logic [jfp_pkg::VALUE_BITS-1:0]       left,
  input  wire logic [jfp_pkg::VALUE_BITS-1:0]       right,
  input  wire logic [jfp_pkg::VALUE_BITS-1:0]       down,
  output logic                                      s1_step,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [jfp_pkg::OUT_TDATA_BITS-1:0]        m_tdata,
  output logic                                      m_tlast
);
  import jfp_pkg::*;

  localparam int SUM_BITS = VALUE_BITS + 2;

  logic signed [SUM_BITS-1:0] sum;
  value_t                     new_value;
  logic [ROW_BITS-1:0]        point_row;
  logic [COL_BITS-1:0]        point_col;
  logic                       last_of_sweep;

  // floor of sum/4 is the arithmetic shift by two
  assign sum = SUM_BITS'(value_t'(up)) + SUM_BITS'(value_t'(left)) +
               SUM_BITS'(value_t'(right)) + SUM_BITS'(value_t'(down));

  assign s1_step = s1_valid && (!s1_pos.emit || !m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_step && s1_pos.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_step && s1_pos.emit) begin
      new_value     <= sum[SUM_BITS-1:2];
      point_row     <= s1_pos.point_row;
      point_col     <= s1_pos.col;
      last_of_sweep <= s1_pos.last;
    end
  end

  assign m_tdata = {{OUT_PAD_BITS{1'b0}}, point_col, point_row, new_value};
  assign m_tlast = last_of_sweep;

`ifndef SYNTHESIS
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_pos.emit && m_tvalid && !m_tready |-> !s1_step)
    else $error("stencil result overwrote a pending word");
  a_load: assert property (@(posedge clk) disable iff (rst)
    s1_step && s1_pos.emit |=> m_tvalid)
    else $error("interior point lost");
  a_border_pass: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_pos.emit |-> s1_step)
    else $error("border point stalled");
`endif

endmodule
`default_nettype wire

// ===== design/jacobi_four_point_stencil.sv =====
`default_nettype none
// Jacobi sweep, four-point stencil, over a grid streamed in raster order.
// s_* : one old grid value per word (signed Q16.16), rows top to bottom,
//       columns left to right. The block knows the frame only by counting.
// m_* : one word per interior point, emitted when the point below it
//       arrives; border points produce no word. m_tlast marks the final
//       interior point of the grid.
// cfg : index 0 = grid_width, index 1 = grid_height, each clamped to
//       [3, max] when used. Write only while no words are in flight.
// Throughput is one word per cycle when the output is not stalled. The
// line-store reads register at the accept edge beside the word, and
// the four-way add and shift load the output register when stage one
// steps, which a held output word can delay for an interior point.
// Reset clears the counters and loads the default size (1024 x 4096);
// line stores are not cleared, the first two rows fill them.
// A stalled m_tready holds the output word; an interior point waiting
// behind it stalls s_tready, while border points pass even when the
// output word is held.
module jacobi_four_point_stencil (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // [31:0] grid_value
  input  wire logic [jfp_pkg::VALUE_BITS-1:0]       s_tdata,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // [31:0] new_value, [43:32] point_row, [53:44] point_col, [55:54] zero
  output logic [jfp_pkg::OUT_TDATA_BITS-1:0]        m_tdata,
  // last_of_sweep
  output logic                                      m_tlast,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [jfp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [jfp_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import jfp_pkg::*;

  logic                  accept;
  pos_t                  pos;
  logic                  s1_valid;
  pos_t                  s1_pos;
  logic [VALUE_BITS-1:0] s1_down;
  logic                  s1_step;

  logic [VALUE_BITS-1:0] older_q;
  logic [VALUE_BITS-1:0] prev_q;
  logic [VALUE_BITS-1:0] right_hold;
  logic [VALUE_BITS-1:0] left_hold;
  logic [VALUE_BITS-1:0] col0_hold;
  logic [VALUE_BITS-1:0] p_value;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !s1_valid || s1_step;

  jfp_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (accept),
    .pos       (pos)
  );

  // old prev_row_store[c]: right of the previous column, or held copy for column 0
  assign p_value = (s1_pos.col == '0) ? col0_hold : right_hold;

  jfp_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_WIDTH)) u_older_row (
    .clk   (clk),
    .we    (s1_step),
    .waddr (s1_pos.col),
    .wdata (p_value),
    .re    (accept),
    .raddr (pos.col),
    .rdata (older_q)
  );

  jfp_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_WIDTH)) u_prev_row (
    .clk   (clk),
    .we    (s1_step),
    .waddr (s1_pos.col),
    .wdata (s1_down),
    .re    (accept),
    .raddr (COL_BITS'(pos.col + COL_BITS'(1))),
    .rdata (prev_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos  <= pos;
      s1_down <= s_tdata;
    end
    if (s1_step) begin
      right_hold <= prev_q;
      left_hold  <= p_value;
      if (s1_pos.col == '0) begin
        col0_hold <= s1_down;
      end
    end
  end

  jfp_stencil u_stencil (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_pos   (s1_pos),
    .up       (older_q),
    .left     (left_hold),
    .right    (prev_q),
    .down     (s1_down),
    .s1_step  (s1_step),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_step |-> !s_tready)
    else $error("input taken while stage one is stuck");
  a_left_neighbor: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_pos.emit |-> s1_pos.col != '0)
    else $error("left neighbor taken from another row");
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_step |=> s1_valid && $stable(s1_pos) && $stable(s1_down))
    else $error("stage one changed while stalled");
`endif

endmodule
`default_nettype wire
